// File: rtl/rv32ex_pkg.sv
// rv32ex_pkg: shared types, codes and helpers for the rv32im execute step
// no dependencies; used by rv32ex_front, rv32ex_back and the top level
package rv32ex_pkg;

  localparam int NUM_REGS = 32;
  localparam int RIDX_W   = $clog2(NUM_REGS);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // major opcodes
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_ALUI   = 7'h13;
  localparam logic [6:0] OPC_ALU    = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  // exact system words
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [31:0] WORD_MRET   = 32'h3020_0073;

  localparam logic [4:0] REG_A0 = 5'd10;

  // csr addresses and slots
  localparam logic [11:0] CSR_MSTATUS  = 12'h300;
  localparam logic [11:0] CSR_MIE      = 12'h304;
  localparam logic [11:0] CSR_MTVEC    = 12'h305;
  localparam logic [11:0] CSR_MSCRATCH = 12'h340;
  localparam logic [11:0] CSR_MEPC     = 12'h341;
  localparam logic [11:0] CSR_MCAUSE   = 12'h342;
  localparam logic [11:0] CSR_MTVAL    = 12'h343;
  localparam logic [11:0] CSR_MIP      = 12'h344;
  localparam logic [11:0] CSR_CYCLE    = 12'hC00;
  localparam logic [11:0] CSR_CYCLEH   = 12'hC80;

  localparam logic [2:0] SLOT_MSTATUS = 3'd0;
  localparam logic [2:0] SLOT_MTVEC   = 3'd2;
  localparam logic [2:0] SLOT_MEPC    = 3'd4;
  localparam logic [2:0] SLOT_MCAUSE  = 3'd5;

  localparam logic [31:0] MSTATUS_TRAP = 32'h0000_1800;
  localparam logic [31:0] MSTATUS_MRET = 32'h0000_1888;
  localparam logic [31:0] CAUSE_ECALL  = 32'd11;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_ILL  = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;

  typedef enum logic [4:0] {
    K_LUI, K_AUIPC, K_JAL, K_JALR, K_BR, K_ST, K_LD, K_ALUI, K_ALU,
    K_MUL, K_DIV, K_ECALL, K_EBREAK, K_MRET, K_CSR, K_ILL, K_LDRET
  } kind_t;

  // one classified word in the queue
  typedef struct packed {
    kind_t       kind;
    logic [31:0] instr;
    logic [31:0] pc;
    logic [31:0] ld_data;
    logic [31:0] imm;
    logic [4:0]  rs1a;
    logic [4:0]  rs2a;
  } dec_t;

  typedef struct packed {
    logic valid;
    dec_t head;
  } qhead_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [4:0]  rd_index;
    logic [31:0] rd_value;
    logic        rd_write;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic [31:0] store_data;
    logic [1:0]  status;
    logic [31:0] halt_code;
  } res_t;

  // {hit, slot}
  function automatic logic [3:0] csr_slot(input logic [11:0] a);
    logic [3:0] s;
    case (a)
      CSR_MSTATUS:  s = 4'h8;
      CSR_MIE:      s = 4'h9;
      CSR_MTVEC:    s = 4'hA;
      CSR_MSCRATCH: s = 4'hB;
      CSR_MEPC:     s = 4'hC;
      CSR_MCAUSE:   s = 4'hD;
      CSR_MTVAL:    s = 4'hE;
      CSR_MIP:      s = 4'hF;
      default:      s = 4'h0;
    endcase
    return s;
  endfunction

  function automatic logic reg_live(input logic [4:0] idx);
    return (idx != 5'd0) && (32'(idx) < NUM_REGS);
  endfunction

endpackage

// File: rtl/rv32ex_if.sv
// rv32ex channel interfaces: instruction/load-return input and result output
// depends on nothing; payload widths fixed by the block's fields
interface rv32ex_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] instr;
  logic [31:0] pc;
  logic [31:0] load_data;

  modport source (output valid, op, instr, pc, load_data, input ready);
  modport sink   (input valid, op, instr, pc, load_data, output ready);
endinterface

interface rv32ex_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [4:0]  rd_index;
  logic [31:0] rd_value;
  logic        rd_write;
  logic        mem_read;
  logic        mem_write;
  logic [31:0] mem_addr;
  logic [1:0]  mem_size;
  logic [31:0] store_data;
  logic [1:0]  status;
  logic [31:0] halt_code;

  modport source (output valid, next_pc, rd_index, rd_value, rd_write, mem_read, mem_write,
                  mem_addr, mem_size, store_data, status, halt_code, input ready);
  modport sink   (input valid, next_pc, rd_index, rd_value, rd_write, mem_read, mem_write,
                  mem_addr, mem_size, store_data, status, halt_code, output ready);
endinterface

// File: rtl/rv32ex_front.sv
// rv32ex_front: accepts input words, classifies them and queues them
// depends on rv32ex_pkg and rv32ex_in_if
module rv32ex_front (
  input  logic                 clk,
  input  logic                 rst_n,
  rv32ex_in_if.sink            in_ch,
  output rv32ex_pkg::qhead_t   q_o,
  input  logic                 q_pop
);

  rv32ex_pkg::dec_t                 dec;
  rv32ex_pkg::dec_t                 fifo_r [rv32ex_pkg::QDEPTH];
  logic [rv32ex_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [rv32ex_pkg::QCNT_W-1:0]    cnt_r;
  logic                             push;
  logic [6:0]                       opc, f7;
  logic [2:0]                       f3;
  logic [31:0]                      i;

  // decode
  always_comb begin
    i   = in_ch.instr;
    opc = i[6:0];
    f3  = i[14:12];
    f7  = i[31:25];
    dec.instr   = i;
    dec.pc      = in_ch.pc;
    dec.ld_data = in_ch.load_data;
    dec.rs1a    = i[19:15];
    dec.rs2a    = i[24:20];
    dec.imm     = {{20{i[31]}}, i[31:20]};
    dec.kind    = rv32ex_pkg::K_ILL;
    if (in_ch.op) begin
      dec.kind = rv32ex_pkg::K_LDRET;
    end else begin
      case (opc)
        rv32ex_pkg::OPC_LUI: begin
          dec.kind = rv32ex_pkg::K_LUI;
          dec.imm  = {i[31:12], 12'b0};
        end
        rv32ex_pkg::OPC_AUIPC: begin
          dec.kind = rv32ex_pkg::K_AUIPC;
          dec.imm  = {i[31:12], 12'b0};
        end
        rv32ex_pkg::OPC_JAL: begin
          dec.kind = rv32ex_pkg::K_JAL;
          dec.imm  = {{11{i[31]}}, i[31], i[19:12], i[20], i[30:21], 1'b0};
        end
        rv32ex_pkg::OPC_JALR: begin
          if (f3 == 3'd0) dec.kind = rv32ex_pkg::K_JALR;
        end
        rv32ex_pkg::OPC_BRANCH: begin
          dec.imm = {{19{i[31]}}, i[31], i[7], i[30:25], i[11:8], 1'b0};
          if (f3 != 3'd2 && f3 != 3'd3) dec.kind = rv32ex_pkg::K_BR;
        end
        rv32ex_pkg::OPC_STORE: begin
          dec.imm = {{20{i[31]}}, i[31:25], i[11:7]};
          if (f3 <= 3'd2) dec.kind = rv32ex_pkg::K_ST;
        end
        rv32ex_pkg::OPC_LOAD: begin
          if (f3 != 3'd3 && f3 <= 3'd5) dec.kind = rv32ex_pkg::K_LD;
        end
        rv32ex_pkg::OPC_ALUI: begin
          if (f3 == 3'd1) begin
            if (f7 == rv32ex_pkg::F7_BASE) dec.kind = rv32ex_pkg::K_ALUI;
          end else if (f3 == 3'd5) begin
            if (f7 == rv32ex_pkg::F7_BASE || f7 == rv32ex_pkg::F7_ALT)
              dec.kind = rv32ex_pkg::K_ALUI;
          end else begin
            dec.kind = rv32ex_pkg::K_ALUI;
          end
        end
        rv32ex_pkg::OPC_ALU: begin
          if (f7 == rv32ex_pkg::F7_MULDIV)
            dec.kind = f3[2] ? rv32ex_pkg::K_DIV : rv32ex_pkg::K_MUL;
          else if (f7 == rv32ex_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5))
            dec.kind = rv32ex_pkg::K_ALU;
          else if (f7 == rv32ex_pkg::F7_BASE)
            dec.kind = rv32ex_pkg::K_ALU;
        end
        rv32ex_pkg::OPC_SYSTEM: begin
          if (f3 == 3'd0) begin
            if (i == rv32ex_pkg::WORD_EBREAK) begin
              dec.kind = rv32ex_pkg::K_EBREAK;
              dec.rs1a = rv32ex_pkg::REG_A0;
            end else if (i == rv32ex_pkg::WORD_ECALL) begin
              dec.kind = rv32ex_pkg::K_ECALL;
            end else if (i == rv32ex_pkg::WORD_MRET) begin
              dec.kind = rv32ex_pkg::K_MRET;
            end
          end else if (f3 != 3'd4) begin
            dec.kind = rv32ex_pkg::K_CSR;
          end
        end
        default: dec.kind = rv32ex_pkg::K_ILL;
      endcase
    end
  end

  // queue control
  assign in_ch.ready = (cnt_r != rv32ex_pkg::QCNT_W'(rv32ex_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_o.valid   = (cnt_r != '0);
  assign q_o.head    = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !q_pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && q_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= dec;
  end

endmodule

// File: rtl/rv32ex_back.sv
// rv32ex_back: register file, csrs, alu, multiplier, iterative divider, result register
// depends on rv32ex_pkg and rv32ex_out_if
module rv32ex_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rv32ex_pkg::qhead_t   q_i,
  output logic                 q_pop,
  rv32ex_out_if.source         out_ch
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_EX   = 4'b0010,
    B_MUL  = 4'b0100,
    B_DIV  = 4'b1000
  } bstate_t;

  bstate_t                          state_r, state_nxt;
  rv32ex_pkg::dec_t                 it_r;
  logic [31:0]                      rf_mem [rv32ex_pkg::NUM_REGS];
  logic [rv32ex_pkg::NUM_REGS-1:0]  rf_vld_r;
  logic [31:0]                      a_mem_r, b_mem_r;
  logic                             a_ok_r, b_ok_r;
  logic [31:0]                      a, b;
  logic [31:0]                      csr_r [8];
  logic [63:0]                      cycle_r;
  logic [4:0]                       pend_reg_r;
  logic [1:0]                       pend_size_r;
  logic                             pend_sgn_r;
  logic [65:0]                      mul_r;
  logic [31:0]                      quo_r, rem_r, dvs_r;
  logic [4:0]                       dcnt_r;
  logic                             div_done_r, neg_q_r, neg_r_r;
  rv32ex_pkg::res_t                 res, out_r;
  logic                             out_valid_r, out_free, fin, rf_we;
  logic [2:0]                       f3;
  logic [4:0]                       rd;
  logic [31:0]                      op2, alu_v, wbv, csr_old, csr_src, csr_new, ldv;
  logic [31:0]                      div_q, div_rv, mag_a, mag_b;
  logic [3:0]                       slot;
  logic                             haswb, taken, dsgn;
  logic [32:0]                      drs, ddiff;

  assign f3 = it_r.instr[14:12];
  assign rd = it_r.instr[11:7];
  assign a  = a_ok_r ? a_mem_r : '0;
  assign b  = b_ok_r ? b_mem_r : '0;
  assign q_pop = (state_r == B_IDLE) && q_i.valid;

  // register file read, data registered
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_mem_r <= rf_mem[q_i.head.rs1a[rv32ex_pkg::RIDX_W-1:0]];
      b_mem_r <= rf_mem[q_i.head.rs2a[rv32ex_pkg::RIDX_W-1:0]];
      it_r    <= q_i.head;
    end
    if (rf_we) rf_mem[res.rd_index[rv32ex_pkg::RIDX_W-1:0]] <= res.rd_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ok_r <= 1'b0;
      b_ok_r <= 1'b0;
    end else if (q_pop) begin
      a_ok_r <= rv32ex_pkg::reg_live(q_i.head.rs1a) &&
                rf_vld_r[q_i.head.rs1a[rv32ex_pkg::RIDX_W-1:0]];
      b_ok_r <= rv32ex_pkg::reg_live(q_i.head.rs2a) &&
                rf_vld_r[q_i.head.rs2a[rv32ex_pkg::RIDX_W-1:0]];
    end
  end

  // alu
  always_comb begin
    op2 = (it_r.kind == rv32ex_pkg::K_ALUI) ? it_r.imm : b;
    case (f3)
      3'd0: alu_v = (it_r.kind == rv32ex_pkg::K_ALU && it_r.instr[30]) ? a - op2 : a + op2;
      3'd1: alu_v = a << op2[4:0];
      3'd2: alu_v = {31'b0, $signed(a) < $signed(op2)};
      3'd3: alu_v = {31'b0, a < op2};
      3'd4: alu_v = a ^ op2;
      3'd5: alu_v = it_r.instr[30] ? 32'($signed(a) >>> op2[4:0]) : a >> op2[4:0];
      3'd6: alu_v = a | op2;
      3'd7: alu_v = a & op2;
      default: alu_v = '0;
    endcase
    case (f3)
      3'd0: taken = (a == b);
      3'd1: taken = (a != b);
      3'd4: taken = $signed(a) < $signed(b);
      3'd5: taken = !($signed(a) < $signed(b));
      3'd6: taken = a < b;
      3'd7: taken = a >= b;
      default: taken = 1'b0;
    endcase
  end

  // csr read-modify-write
  always_comb begin
    slot = rv32ex_pkg::csr_slot(it_r.instr[31:20]);
    if (slot[3]) csr_old = csr_r[slot[2:0]];
    else if (it_r.instr[31:20] == rv32ex_pkg::CSR_CYCLE) csr_old = cycle_r[31:0];
    else if (it_r.instr[31:20] == rv32ex_pkg::CSR_CYCLEH) csr_old = cycle_r[63:32];
    else csr_old = '1;
    csr_src = f3[2] ? {27'b0, it_r.instr[19:15]} : a;
    case (f3[1:0])
      2'd1: csr_new = csr_src;
      2'd2: csr_new = csr_old | csr_src;
      default: csr_new = csr_old & ~csr_src;
    endcase
  end

  // load return extension
  always_comb begin
    if (pend_size_r == rv32ex_pkg::SZ_BYTE)
      ldv = pend_sgn_r ? {{24{it_r.ld_data[7]}}, it_r.ld_data[7:0]}
                       : {24'b0, it_r.ld_data[7:0]};
    else if (pend_size_r == rv32ex_pkg::SZ_HALF)
      ldv = pend_sgn_r ? {{16{it_r.ld_data[15]}}, it_r.ld_data[15:0]}
                       : {16'b0, it_r.ld_data[15:0]};
    else
      ldv = it_r.ld_data;
  end

  // divider operands and result
  always_comb begin
    dsgn   = !f3[0];
    mag_a  = (dsgn && a[31]) ? -a : a;
    mag_b  = (dsgn && b[31]) ? -b : b;
    drs    = {rem_r, quo_r[31]};
    ddiff  = drs - {1'b0, dvs_r};
    div_q  = neg_q_r ? -quo_r : quo_r;
    div_rv = neg_r_r ? -rem_r : rem_r;
  end

  // result word
  always_comb begin
    res       = '0;
    haswb     = 1'b0;
    wbv       = '0;
    res.next_pc = it_r.pc + 32'd4;
    case (it_r.kind)
      rv32ex_pkg::K_LUI: begin haswb = 1'b1; wbv = it_r.imm; end
      rv32ex_pkg::K_AUIPC: begin haswb = 1'b1; wbv = it_r.pc + it_r.imm; end
      rv32ex_pkg::K_JAL: begin
        haswb = 1'b1;
        wbv = it_r.pc + 32'd4;
        res.next_pc = it_r.pc + it_r.imm;
      end
      rv32ex_pkg::K_JALR: begin
        haswb = 1'b1;
        wbv = it_r.pc + 32'd4;
        res.next_pc = (a + it_r.imm) & ~32'd1;
      end
      rv32ex_pkg::K_BR: if (taken) res.next_pc = it_r.pc + it_r.imm;
      rv32ex_pkg::K_ST: begin
        res.mem_write  = 1'b1;
        res.mem_size   = f3[1:0];
        res.store_data = b;
        res.mem_addr   = a + it_r.imm;
      end
      rv32ex_pkg::K_LD: begin
        res.mem_read = 1'b1;
        res.mem_size = f3[1:0];
        res.mem_addr = a + it_r.imm;
      end
      rv32ex_pkg::K_ALUI, rv32ex_pkg::K_ALU: begin haswb = 1'b1; wbv = alu_v; end
      rv32ex_pkg::K_MUL: begin
        haswb = 1'b1;
        wbv = (f3[1:0] == 2'd0) ? mul_r[31:0] : mul_r[63:32];
      end
      rv32ex_pkg::K_DIV: begin
        haswb = 1'b1;
        if (b == '0) wbv = f3[1] ? a : '1;
        else wbv = f3[1] ? div_rv : div_q;
      end
      rv32ex_pkg::K_ECALL: res.next_pc = csr_r[rv32ex_pkg::SLOT_MTVEC];
      rv32ex_pkg::K_MRET: res.next_pc = csr_r[rv32ex_pkg::SLOT_MEPC];
      rv32ex_pkg::K_EBREAK: begin
        res.status    = rv32ex_pkg::ST_HALT;
        res.halt_code = a;
        res.next_pc   = it_r.pc;
      end
      rv32ex_pkg::K_CSR: begin haswb = 1'b1; wbv = csr_old; end
      rv32ex_pkg::K_LDRET: begin
        res.next_pc = '0;
        haswb = 1'b1;
        wbv = ldv;
      end
      default: begin
        res.status  = rv32ex_pkg::ST_ILL;
        res.next_pc = it_r.pc;
      end
    endcase
    if (it_r.kind == rv32ex_pkg::K_LDRET) begin
      if (haswb && rv32ex_pkg::reg_live(pend_reg_r)) begin
        res.rd_write = 1'b1;
        res.rd_index = pend_reg_r;
        res.rd_value = wbv;
      end
    end else if (haswb && rv32ex_pkg::reg_live(rd)) begin
      res.rd_write = 1'b1;
      res.rd_index = rd;
      res.rd_value = wbv;
    end
  end

  // sequencing
  assign out_free = !out_valid_r || out_ch.ready;
  always_comb begin
    state_nxt = state_r;
    fin = 1'b0;
    case (state_r)
      B_IDLE: if (q_i.valid) state_nxt = B_EX;
      B_EX: begin
        if (it_r.kind == rv32ex_pkg::K_MUL) state_nxt = B_MUL;
        else if (it_r.kind == rv32ex_pkg::K_DIV && b != '0) state_nxt = B_DIV;
        else if (out_free) begin
          fin = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      B_MUL: if (out_free) begin
        fin = 1'b1;
        state_nxt = B_IDLE;
      end
      B_DIV: if (div_done_r && out_free) begin
        fin = 1'b1;
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end
  assign rf_we = fin && res.rd_write;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else state_r <= state_nxt;
  end

  // multiplier, one registered product
  always_ff @(posedge clk) begin
    if (state_r == B_EX && it_r.kind == rv32ex_pkg::K_MUL)
      mul_r <= $signed({f3[1:0] != 2'd3 && a[31], a}) * $signed({f3[1:0] == 2'd1 && b[31], b});
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (state_r == B_EX) begin
      quo_r   <= mag_a;
      rem_r   <= '0;
      dvs_r   <= mag_b;
      neg_q_r <= dsgn && (a[31] ^ b[31]);
      neg_r_r <= dsgn && a[31];
    end else if (state_r == B_DIV && !div_done_r) begin
      if (!ddiff[32]) begin
        rem_r <= ddiff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= drs[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r     <= '0;
      div_done_r <= 1'b0;
    end else if (state_r == B_EX) begin
      dcnt_r     <= '0;
      div_done_r <= 1'b0;
    end else if (state_r == B_DIV && !div_done_r) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (dcnt_r == '1) div_done_r <= 1'b1;
    end
  end

  // architectural state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r    <= '0;
      cycle_r     <= '0;
      pend_reg_r  <= '0;
      pend_size_r <= '0;
      pend_sgn_r  <= 1'b0;
      for (int k = 0; k < 8; k++) csr_r[k] <= '0;
    end else if (fin) begin
      if (rf_we) rf_vld_r[res.rd_index[rv32ex_pkg::RIDX_W-1:0]] <= 1'b1;
      if (it_r.kind != rv32ex_pkg::K_LDRET) cycle_r <= cycle_r + 64'd1;
      if (it_r.kind == rv32ex_pkg::K_LD) begin
        pend_reg_r  <= rd;
        pend_size_r <= f3[1:0];
        pend_sgn_r  <= !f3[2];
      end
      if (it_r.kind == rv32ex_pkg::K_ECALL) begin
        csr_r[rv32ex_pkg::SLOT_MEPC]    <= it_r.pc;
        csr_r[rv32ex_pkg::SLOT_MCAUSE]  <= rv32ex_pkg::CAUSE_ECALL;
        csr_r[rv32ex_pkg::SLOT_MSTATUS] <= rv32ex_pkg::MSTATUS_TRAP;
      end
      if (it_r.kind == rv32ex_pkg::K_MRET)
        csr_r[rv32ex_pkg::SLOT_MSTATUS] <= rv32ex_pkg::MSTATUS_MRET;
      if (it_r.kind == rv32ex_pkg::K_CSR && slot[3]) csr_r[slot[2:0]] <= csr_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (fin) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fin) out_r <= res;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.next_pc    = out_r.next_pc;
  assign out_ch.rd_index   = out_r.rd_index;
  assign out_ch.rd_value   = out_r.rd_value;
  assign out_ch.rd_write   = out_r.rd_write;
  assign out_ch.mem_read   = out_r.mem_read;
  assign out_ch.mem_write  = out_r.mem_write;
  assign out_ch.mem_addr   = out_r.mem_addr;
  assign out_ch.mem_size   = out_r.mem_size;
  assign out_ch.store_data = out_r.store_data;
  assign out_ch.status     = out_r.status;
  assign out_ch.halt_code  = out_r.halt_code;

  // checks
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> res.rd_index != 5'd0) else $error("write to x0");
  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (!out_valid_r || out_ch.ready)) else $error("result overwritten");
  a_mul_after_ex: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_MUL |-> $past(state_r) == B_EX || $past(state_r) == B_MUL)
    else $error("mul entered wrongly");

endmodule

// File: rtl/rv32im_csr_execute_step.sv
// rv32im_csr_execute_step: top level, joins the classifying front and the execute back
// depends on rv32ex_pkg, rv32ex_if, rv32ex_front and rv32ex_back
//
// Each input word is either an instruction (op 0) or the data of the pending load (op 1)
// and yields exactly one result word. The front classifies words into a two-entry queue,
// so input keeps flowing while the back works. The back handles each word in two steps: the
// registered register-file read, then execution and the load of the result register.
// mul/mulh* add a state for the registered product; div/rem with a nonzero divisor add the
// one-bit-per-cycle divider. A waiting result stalls only the back.
module rv32im_csr_execute_step (
  input logic         clk,
  input logic         rst_n,
  rv32ex_in_if.sink   in_ch,
  rv32ex_out_if.source out_ch
);

  rv32ex_pkg::qhead_t q;
  logic               q_pop;

  rv32ex_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_o   (q),
    .q_pop (q_pop)
  );

  rv32ex_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_i    (q),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
